// ===== sv/cfr_pkg.sv =====
// Shared types and constants for the checksummed frame receiver.
`timescale 1ns / 1ps
package cfr_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CfgHeader  = 2'd0;
  localparam logic [1:0] CfgDataTyp = 2'd1;
  localparam logic [1:0] CfgAckTyp  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] HeaderReset  = 8'h55;
  localparam logic [7:0] DataTypReset = 8'h01;
  localparam logic [7:0] AckTypReset  = 8'h02;

  // Header size in bytes, counted in the length field
  localparam logic [15:0] HeaderBytes = 16'd8;
  localparam logic [15:0] PrevIdReset = 16'hffff;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_TYPE    = 4'd1,
    PH_ID_HI   = 4'd2,
    PH_ID_LO   = 4'd3,
    PH_CHK_HI  = 4'd4,
    PH_CHK_LO  = 4'd5,
    PH_LEN_HI  = 4'd6,
    PH_LEN_LO  = 4'd7,
    PH_PAYLOAD = 4'd8
  } cfr_phase_e;

  // Event codes reported per byte
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_DUP     = 3'd3,
    EV_BAD_CHK = 3'd4,
    EV_ACK     = 3'd5,
    EV_BAD_LEN = 3'd6
  } cfr_event_e;

  // One result item
  typedef struct packed {
    cfr_event_e  evt;
    logic [7:0]  payload;
    logic [15:0] msg_id;
    logic [15:0] checksum;
    logic [15:0] length;
  } cfr_result_t;

endpackage

// ===== sv/checksummed_frame_receiver.sv =====
// Top level of the checksummed frame receiver.
`timescale 1ns / 1ps
// Usage:
//   rx channel (rx_valid_i/rx_ready_o, rx_byte_i) takes one received byte per
//   transfer. The res channel (res_valid_o/res_ready_i) gives exactly one
//   result per accepted byte, in order: an event code with the payload byte
//   and, on frame end events, the id, checksum and length from the header.
//   The configuration port (cfg_we_i, cfg_index_i, cfg_wdata_i) writes the
//   header byte or a type code, as cfg_index_i picks; write only while idle.
//   The result of an accepted byte is registered in the result register, or
//   in the skid register while a result waits. It takes one byte per cycle
//   while rx_ready_o is high; the parse state advances in the same cycle as
//   the byte is taken, with one short decode before the result register.
//   Stalls: a two-entry output buffer lets one more byte in while a result
//   waits; rx_ready_o falls only once both entries hold results.
//   Reset: the parser hunts for a header, the registers take their default
//   codes, the last good id reads all ones and the output buffer empties.
module checksummed_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] message_id_o,
  output logic [15:0] frame_checksum_o,
  output logic [15:0] frame_length_o
);
  import cfr_pkg::*;

  cfr_result_t parse_res, out_res;
  logic        rx_fire;

  assign rx_fire = rx_valid_i && rx_ready_o;

  // Per-byte parser
  cfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_fire_i (rx_fire),
    .byte_i      (rx_byte_i),
    .res_o       (parse_res)
  );

  // Result buffer
  cfr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_valid_i),
    .in_ready_o  (rx_ready_o),
    .in_data_i   (parse_res),
    .out_valid_o (res_valid_o),
    .out_ready_i (res_ready_i),
    .out_data_o  (out_res)
  );

  assign event_res_o      = out_res.evt;
  assign payload_byte_o   = out_res.payload;
  assign message_id_o     = out_res.msg_id;
  assign frame_checksum_o = out_res.checksum;
  assign frame_length_o   = out_res.length;

endmodule

// ===== sv/cfr_parser.sv =====
// Byte-wise frame parser: config registers, parse state and result decode.
`timescale 1ns / 1ps
module cfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                byte_fire_i,
  input  logic [7:0]          byte_i,
  output cfr_pkg::cfr_result_t res_o
);
  import cfr_pkg::*;

  logic [7:0]  header_q, data_typ_q, ack_typ_q;
  cfr_phase_e  phase_q, phase_d;
  logic        ack_q, ack_d;
  logic [15:0] id_q, id_d;
  logic [15:0] chk_q, chk_d;
  logic [15:0] len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] prev_q, prev_d;

  logic [15:0] len_full, sum_inc, pos_inc;
  logic        type_hit, last_byte;

  assign len_full  = {len_q[15:8], byte_i};
  assign sum_inc   = sum_q + {8'h00, byte_i};
  assign pos_inc   = pos_q + 16'd1;
  assign type_hit  = (byte_i == data_typ_q) || (byte_i == ack_typ_q);
  assign last_byte = (pos_inc == len_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= HeaderReset;
      data_typ_q <= DataTypReset;
      ack_typ_q  <= AckTypReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgHeader:  header_q   <= cfg_wdata_i;
        CfgDataTyp: data_typ_q <= cfg_wdata_i;
        CfgAckTyp:  ack_typ_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HUNT:    if (byte_i == header_q) phase_d = PH_TYPE;
      PH_TYPE:    phase_d = type_hit ? PH_ID_HI : PH_HUNT;
      PH_ID_HI:   phase_d = PH_ID_LO;
      PH_ID_LO:   phase_d = PH_CHK_HI;
      PH_CHK_HI:  phase_d = PH_CHK_LO;
      PH_CHK_LO:  phase_d = PH_LEN_HI;
      PH_LEN_HI:  phase_d = PH_LEN_LO;
      PH_LEN_LO: begin
        if (ack_q || (len_full <= HeaderBytes)) phase_d = PH_HUNT;
        else phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: if (last_byte) phase_d = PH_HUNT;
      default:    phase_d = PH_HUNT;
    endcase
  end

  // Field capture and result decode
  always_comb begin
    ack_d  = ack_q;
    id_d   = id_q;
    chk_d  = chk_q;
    len_d  = len_q;
    sum_d  = sum_q;
    pos_d  = pos_q;
    prev_d = prev_q;
    res_o  = '{evt: EV_NONE, payload: 8'h00, msg_id: 16'h0000,
               checksum: 16'h0000, length: 16'h0000};
    unique case (phase_q)
      PH_TYPE: begin
        if (type_hit) begin
          ack_d = (byte_i != data_typ_q);
          id_d  = 16'h0000;
          chk_d = 16'h0000;
          len_d = 16'h0000;
          sum_d = 16'h0000;
        end
      end
      PH_ID_HI:  id_d  = {byte_i, 8'h00};
      PH_ID_LO:  id_d  = {id_q[15:8], byte_i};
      PH_CHK_HI: chk_d = {byte_i, 8'h00};
      PH_CHK_LO: chk_d = {chk_q[15:8], byte_i};
      PH_LEN_HI: len_d = {byte_i, 8'h00};
      PH_LEN_LO: begin
        len_d = len_full;
        sum_d = 16'h0000;
        pos_d = HeaderBytes;
        if (ack_q || (len_full <= HeaderBytes)) begin
          res_o.evt      = ack_q ? EV_ACK : EV_BAD_LEN;
          res_o.msg_id   = id_q;
          res_o.checksum = chk_q;
          res_o.length   = len_full;
        end
      end
      PH_PAYLOAD: begin
        sum_d         = sum_inc;
        pos_d         = pos_inc;
        res_o.payload = byte_i;
        if (last_byte) begin
          res_o.msg_id   = id_q;
          res_o.checksum = chk_q;
          res_o.length   = len_q;
          if (sum_inc == chk_q) begin
            res_o.evt = (prev_q != id_q) ? EV_GOOD : EV_DUP;
            prev_d    = id_q;
          end else begin
            res_o.evt = EV_BAD_CHK;
          end
        end else begin
          res_o.evt = EV_PAYLOAD;
        end
      end
      default: ;
    endcase
  end

  // Parse state, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      ack_q   <= 1'b0;
      id_q    <= 16'h0000;
      chk_q   <= 16'h0000;
      len_q   <= 16'h0000;
      sum_q   <= 16'h0000;
      pos_q   <= 16'h0000;
      prev_q  <= PrevIdReset;
    end else if (byte_fire_i) begin
      phase_q <= phase_d;
      ack_q   <= ack_d;
      id_q    <= id_d;
      chk_q   <= chk_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      pos_q   <= pos_d;
      prev_q  <= prev_d;
    end
  end

  // A payload phase always has at least one byte left to come
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (len_q > HeaderBytes) && (pos_q < len_q))
    else $error("payload phase with exhausted length");

  // Frame end events only come out of the last header or payload byte
  a_end_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.evt != EV_NONE && res_o.evt != EV_PAYLOAD) |->
      (phase_q == PH_LEN_LO || phase_q == PH_PAYLOAD))
    else $error("frame end event outside a frame end phase");

  // The duplicate id only moves on a good frame transfer
  a_prev_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prev_q != $past(prev_q)) |->
      ($past(byte_fire_i) && ($past(res_o.evt) == EV_GOOD || $past(res_o.evt) == EV_DUP)))
    else $error("previous id changed without a good frame");

endmodule

// ===== sv/cfr_skid.sv =====
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps
module cfr_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfr_pkg::cfr_result_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfr_pkg::cfr_result_t out_data_o
);
  import cfr_pkg::*;

  logic        out_valid_q, skid_valid_q;
  cfr_result_t out_q, skid_q;
  logic        in_fire;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  // The skid entry is only ever filled behind a waiting result
  a_skid_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without a head result");

  // A stalled head result stays put
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

  // A full skid entry drains into the head when the receiver takes a transfer
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q
      && out_q == $past(skid_q)))
    else $error("skid entry lost");

endmodule

// ===== test/checksummed_frame_receiver_tb.sv =====
// Testbench for the checksummed frame receiver: directed table, random frames, scoreboard.
`timescale 1ns / 1ps
module checksummed_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 10;
  localparam int PhaseBytes  = 250;
  localparam int NumPhases   = 6;

  localparam cfr_result_t NoEvent = '{EV_NONE, 8'h00, 16'h0000, 16'h0000, 16'h0000};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_wdata_i;
  logic        rx_valid_i;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i;
  logic        res_valid_o;
  logic        res_ready_i;
  logic [2:0]  event_res_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] message_id_o;
  logic [15:0] frame_checksum_o;
  logic [15:0] frame_length_o;

  checksummed_frame_receiver u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .event_res_o      (event_res_o),
    .payload_byte_o   (payload_byte_o),
    .message_id_o     (message_id_o),
    .frame_checksum_o (frame_checksum_o),
    .frame_length_o   (frame_length_o)
  );

  // Directed stimulus: byte, and a hand-written result where one is given
  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    cfr_result_t res;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] hdr;
    logic [7:0] dat;
    logic [7:0] ack;
  } code_set_t;

  dir_row_t    dir_rows[$];
  logic [7:0]  tx_q[$];
  cfr_result_t byte_results_q[$];
  code_set_t   code_sets[NumPhases];
  int          errors;
  bit          no_idle;
  logic [15:0] gen_last_id;

  // Mirror of the parser state and its registers
  logic [7:0]  m_header;
  logic [7:0]  m_data_code;
  logic [7:0]  m_ack_code;
  cfr_phase_e  m_phase;
  logic        m_is_ack;
  logic [15:0] m_id;
  logic [15:0] m_chk;
  logic [15:0] m_len;
  logic [15:0] m_sum;
  logic [15:0] m_pos;
  logic [15:0] m_last_good_id;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic cfr_result_t frame_end(cfr_event_e ev, logic [7:0] pb);
    cfr_result_t r;
    r = '{ev, pb, m_id, m_chk, m_len};
    return r;
  endfunction

  // Parser prediction for one received byte
  function automatic cfr_result_t parse_byte(logic [7:0] b);
    cfr_result_t r;
    r = NoEvent;
    case (m_phase)
      PH_HUNT: begin
        if (b == m_header) m_phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (b == m_data_code || b == m_ack_code) begin
          // data code wins when both codes match
          m_is_ack = (b != m_data_code);
          m_id     = '0;
          m_chk    = '0;
          m_len    = '0;
          m_sum    = '0;
          m_phase  = PH_ID_HI;
        end else begin
          m_phase = PH_HUNT;
        end
      end
      PH_ID_HI: begin
        m_id    = {b, 8'h00};
        m_phase = PH_ID_LO;
      end
      PH_ID_LO: begin
        m_id    = m_id | {8'h00, b};
        m_phase = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        m_chk   = {b, 8'h00};
        m_phase = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        m_chk   = m_chk | {8'h00, b};
        m_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        m_len   = {b, 8'h00};
        m_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        m_len = m_len | {8'h00, b};
        m_sum = '0;
        m_pos = HeaderBytes;
        if (m_is_ack) begin
          m_phase = PH_HUNT;
          r = frame_end(EV_ACK, 8'h00);
        end else if (m_len <= HeaderBytes) begin
          m_phase = PH_HUNT;
          r = frame_end(EV_BAD_LEN, 8'h00);
        end else begin
          m_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        m_sum = m_sum + {8'h00, b};
        m_pos = m_pos + 16'd1;
        if (m_pos == m_len) begin
          // last payload byte carries the frame end event
          m_phase = PH_HUNT;
          if (m_sum == m_chk) begin
            if (m_last_good_id != m_id) r = frame_end(EV_GOOD, b);
            else r = frame_end(EV_DUP, b);
            m_last_good_id = m_id;
          end else begin
            r = frame_end(EV_BAD_CHK, b);
          end
        end else begin
          r.evt     = EV_PAYLOAD;
          r.payload = b;
        end
      end
      default: m_phase = PH_HUNT;
    endcase
    return r;
  endfunction

  // Random frame generator, built on the current codes
  function automatic void gen_frame();
    int          kind;
    int          r;
    int          n;
    int          cut;
    logic [15:0] id;
    logic [15:0] len;
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  pl[$];
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // line noise
      repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 18) begin
      // header followed by an arbitrary, mostly unknown, type
      tx_q.push_back(m_header);
      tx_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 30) id = gen_last_id;
    else if (r < 55) id = 16'($urandom_range(0, 3));
    else if (r < 62) id = 16'hffff;
    else id = 16'($urandom_range(0, 65535));
    gen_last_id = id;
    tx_q.push_back(m_header);
    if (kind < 28 && m_ack_code != m_data_code) begin
      // acknowledge: any checksum and length
      tx_q.push_back(m_ack_code);
      tx_q.push_back(id[15:8]);
      tx_q.push_back(id[7:0]);
      repeat (4) tx_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    tx_q.push_back((kind < 28) ? m_ack_code : m_data_code);
    sum = '0;
    n   = 0;
    if (kind < 34) begin
      len = 16'($urandom_range(0, 8));
    end else begin
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 80);
      repeat (n) pl.push_back(8'($urandom_range(0, 255)));
      foreach (pl[i]) sum = sum + {8'h00, pl[i]};
      len = 16'(n + 8);
    end
    if ($urandom_range(0, 99) < 75) chk = sum;
    else chk = sum + 16'($urandom_range(1, 65535));
    tx_q.push_back(id[15:8]);
    tx_q.push_back(id[7:0]);
    tx_q.push_back(chk[15:8]);
    tx_q.push_back(chk[7:0]);
    tx_q.push_back(len[15:8]);
    tx_q.push_back(len[7:0]);
    // now and then cut the payload short
    cut = (n > 0 && $urandom_range(0, 99) < 5) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < cut; i++) tx_q.push_back(pl[i]);
  endfunction

  function automatic void add_row(logic [7:0] b, bit typed, cfr_result_t res);
    dir_row_t row;
    row.rx    = b;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  // One byte transfer on the rx channel
  task automatic send_byte(logic [7:0] b, bit typed, cfr_result_t typed_res);
    int          gap;
    cfr_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    pred = parse_byte(b);
    byte_results_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgHeader:  m_header    = val;
      CfgDataTyp: m_data_code = val;
      CfgAckTyp:  m_ack_code  = val;
      default: ;
    endcase
  endtask

  // Wait until every result is in, then let the block settle
  task automatic drain();
    rx_valid_i <= 1'b0;
    while (byte_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic check_result(cfr_result_t exp);
    if (event_res_o !== exp.evt) begin
      $error("event_res: expected %0d, got %0d", exp.evt, event_res_o);
      errors++;
    end
    if (payload_byte_o !== exp.payload) begin
      $error("payload_byte: expected %0h, got %0h", exp.payload, payload_byte_o);
      errors++;
    end
    if (message_id_o !== exp.msg_id) begin
      $error("message_id: expected %0h, got %0h", exp.msg_id, message_id_o);
      errors++;
    end
    if (frame_checksum_o !== exp.checksum) begin
      $error("frame_checksum: expected %0h, got %0h", exp.checksum, frame_checksum_o);
      errors++;
    end
    if (frame_length_o !== exp.length) begin
      $error("frame_length: expected %0h, got %0h", exp.length, frame_length_o);
      errors++;
    end
  endtask

  // Result side: random back-pressure
  initial begin
    int on_len;
    int off_len;
    res_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      on_len = $urandom_range(1, 20);
      res_ready_i <= 1'b1;
      repeat (on_len) @(posedge clk_i);
      off_len = pick_gap();
      if (off_len > 0) begin
        res_ready_i <= 1'b0;
        repeat (off_len) @(posedge clk_i);
      end
    end
  end

  // Scoreboard on the result channel
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (byte_results_q.size() == 0) begin
        $error("event_res: expected no result, got %0d", event_res_o);
        errors++;
      end else begin
        check_result(byte_results_q.pop_front());
      end
    end
  end

  // Watchdog: too long with no transfer on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((rx_valid_i && rx_ready_o) || (res_valid_o && res_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence
  initial begin
    cfg_we_i       = 1'b0;
    cfg_index_i    = CfgHeader;
    cfg_wdata_i    = 8'h00;
    rx_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    errors         = 0;
    no_idle        = 1'b0;
    gen_last_id    = 16'h0000;
    m_header       = HeaderReset;
    m_data_code    = DataTypReset;
    m_ack_code     = AckTypReset;
    m_phase        = PH_HUNT;
    m_is_ack       = 1'b0;
    m_id           = '0;
    m_chk          = '0;
    m_len          = '0;
    m_sum          = '0;
    m_pos          = '0;
    m_last_good_id = PrevIdReset;

    // Code sets per random phase; the first keeps the reset codes
    code_sets[0] = '{HeaderReset, DataTypReset, AckTypReset};
    code_sets[1] = '{8'h00, 8'hFF, 8'h80};
    code_sets[2] = '{8'hFF, 8'h00, 8'h00};
    code_sets[3] = '{8'hA5, 8'h3C, 8'hFF};
    code_sets[4] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))};
    code_sets[5] = '{HeaderReset, DataTypReset, AckTypReset};

    // Noise, then an acknowledge with zero checksum and length
    add_row(8'h00, 1'b1, NoEvent);
    add_row(8'h55, 1'b1, NoEvent);
    add_row(8'h02, 1'b0, NoEvent);
    add_row(8'hFF, 1'b0, NoEvent);
    add_row(8'hFF, 1'b0, NoEvent);
    add_row(8'h00, 1'b0, NoEvent);
    add_row(8'h00, 1'b0, NoEvent);
    add_row(8'h00, 1'b0, NoEvent);
    add_row(8'h00, 1'b1, '{EV_ACK, 8'h00, 16'hFFFF, 16'h0000, 16'h0000});
    // Data frame whose length leaves no payload
    add_row(8'h55, 1'b0, NoEvent);
    add_row(8'h01, 1'b0, NoEvent);
    add_row(8'h12, 1'b0, NoEvent);
    add_row(8'h34, 1'b0, NoEvent);
    add_row(8'hAB, 1'b0, NoEvent);
    add_row(8'hCD, 1'b0, NoEvent);
    add_row(8'h00, 1'b0, NoEvent);
    add_row(8'h08, 1'b1, '{EV_BAD_LEN, 8'h00, 16'h1234, 16'hABCD, 16'h0008});
    // One-byte payload, id equal to the reset last id: a duplicate
    add_row(8'h55, 1'b0, NoEvent);
    add_row(8'h01, 1'b0, NoEvent);
    add_row(8'hFF, 1'b0, NoEvent);
    add_row(8'hFF, 1'b0, NoEvent);
    add_row(8'h00, 1'b0, NoEvent);
    add_row(8'hFF, 1'b0, NoEvent);
    add_row(8'h00, 1'b0, NoEvent);
    add_row(8'h09, 1'b0, NoEvent);
    add_row(8'hFF, 1'b1, '{EV_DUP, 8'hFF, 16'hFFFF, 16'h00FF, 16'h0009});
    // Unknown type byte sends the parser back to hunting
    add_row(8'h55, 1'b0, NoEvent);
    add_row(8'h07, 1'b1, NoEvent);

    wait (rst_ni);
    @(posedge clk_i);
    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // Random frames under several code sets
    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        write_reg(CfgHeader, code_sets[p].hdr);
        write_reg(CfgDataTyp, code_sets[p].dat);
        write_reg(CfgAckTyp, code_sets[p].ack);
      end
      tx_q.delete();
      while (tx_q.size() < PhaseBytes) gen_frame();
      foreach (tx_q[i]) begin
        if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_byte(tx_q[i], 1'b0, NoEvent);
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cfr_pkg.sv
sv/cfr_parser.sv
sv/cfr_skid.sv
sv/checksummed_frame_receiver.sv
test/checksummed_frame_receiver_tb.sv
